// ===== rtl/b2da_pkg.sv =====
// shared widths, types and character codes for the decimal text converter
package b2da_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned DigW    = 4;
  localparam int unsigned BcdW    = NumDig * DigW;
  localparam int unsigned DigIdxW = $clog2(NumDig);

  typedef logic [WordW-1:0]   word_t;
  typedef logic [BcdW-1:0]    bcd_t;
  typedef logic [DigW-1:0]    digit_t;
  typedef logic [DigIdxW-1:0] dig_idx_t;
  typedef logic [7:0]         char_t;

  localparam char_t CharZero  = 8'h30;
  localparam char_t CharMinus = 8'h2D;

  localparam logic ActUnsigned = 1'b0;
  localparam logic ActSigned   = 1'b1;

endpackage

// ===== rtl/b2da_if.sv =====
// item channels: input word with mode, output character
interface b2da_in_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           value;
  logic                  action;

  modport source (output valid, value, action, input ready);
  modport sink   (input valid, value, action, output ready);
endinterface

interface b2da_out_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            text_char;
  logic                  last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// top level: 32-bit word to decimal ascii text, one character per output item
//
// in_i carries a 32-bit value and an action bit (0 unsigned, 1 two's
// complement). out_o carries one ascii character per item, most significant
// first, with last_char high on the final one. negative signed values start
// with '-'; zero gives a single '0'; there are never leading zeros.
// an accepted item goes through the shift-and-add-3 unit, one bit per cycle;
// then the leading digit is found and the character emitter sends the
// characters (1 to 11), one per cycle while the receiver is ready.
// in_i.ready is high only while the block is idle; the last character may
// still sit in the output register while the next item is taken.
// a stalled receiver holds the output register and the emitter waits.
// reset clears the sequencer and the output valid flag; no item is in flight.
module binary_to_decimal_ascii_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  b2da_in_if.sink    in_i,
  b2da_out_if.source out_o
);
  import b2da_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;
  logic       neg_q, neg_d;
  dig_idx_t   idx_q, idx_d;
  logic       ov_q, ov_d;
  char_t      char_q, char_d;
  logic       last_q, last_d;

  logic       accept;
  logic       neg_in;
  word_t      mag;
  logic       conv_done;
  bcd_t       bcd;
  digit_t     dig [NumDig];
  dig_idx_t   msd;
  logic       load;

  assign accept = in_i.valid && (state_q == StIdle);
  assign neg_in = (in_i.action == ActSigned) && in_i.value[WordW-1];
  assign mag    = neg_in ? (~in_i.value + word_t'(1)) : in_i.value;

  b2da_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      dig[i] = bcd[i*DigW +: DigW];
    end
  end

  // leading nonzero digit, digit zero when the value is zero
  always_comb begin
    msd = '0;
    for (int i = 1; i < NumDig; i++) begin
      if (dig[i] != '0) begin
        msd = DigIdxW'(i);
      end
    end
  end

  assign load = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_o.ready;
    char_d  = char_q;
    last_d  = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d   = neg_in;
          state_d = StConv;
        end
      end
      StConv: begin
        if (conv_done) begin
          idx_d   = msd;
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (load) begin
          char_d  = CharMinus;
          last_d  = 1'b0;
          ov_d    = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (load) begin
          char_d = CharZero + char_t'(dig[idx_q]);
          last_d = (idx_q == '0);
          ov_d   = 1'b1;
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_i.ready      = (state_q == StIdle);
  assign out_o.valid     = ov_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;

endmodule

// ===== rtl/b2da_dabble.sv =====
// iterative shift-and-add-3 binary to bcd unit, one bit per cycle
module b2da_dabble (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  b2da_pkg::word_t mag_i,
  output logic          done_o,
  output b2da_pkg::bcd_t  bcd_o
);
  import b2da_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  word_t           bin_q, bin_d;
  bcd_t            bcd_q, bcd_d;
  bcd_t            adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  // add-3 correction on each digit
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*DigW +: DigW] > digit_t'(4)) begin
        adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW] + digit_t'(3);
      end else begin
        adj[i*DigW +: DigW] = bcd_q[i*DigW +: DigW];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[WordW-1]};
      bin_d = {bin_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== verif/b2da_checker.sv =====
// checker for the decimal text converter: predicts the characters of each item and compares
module b2da_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2da_in_if          in_mon_i,
  b2da_out_if         out_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import b2da_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_item_t;

  text_item_t  expected_text[$];
  int unsigned mismatches = 0;

  function automatic void queue_decimal_text(word_t word, logic act);
    logic        neg;
    word_t       mag;
    digit_t      digs[NumDig];
    int unsigned nd;
    text_item_t  item;
    neg = (act == ActSigned) && word[WordW-1];
    mag = neg ? (~word + word_t'(1)) : word;
    nd  = 0;
    do begin
      digs[nd] = digit_t'(mag % 10);
      mag      = mag / 10;
      nd++;
    end while (mag != 0);
    if (neg) begin
      item.ch   = CharMinus;
      item.last = 1'b0;
      expected_text.push_back(item);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      item.ch   = CharZero + char_t'(digs[i]);
      item.last = (i == 0);
      expected_text.push_back(item);
    end
  endfunction

  always @(posedge clk_i) begin
    text_item_t want;
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        queue_decimal_text(in_mon_i.value, in_mon_i.action);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none, actual char %h last %b",
                   $time, out_mon_i.text_char, out_mon_i.last_char);
        end else begin
          want = expected_text.pop_front();
          if (out_mon_i.text_char !== want.ch || out_mon_i.last_char !== want.last) begin
            mismatches++;
            $display("%0t: expected char %h last %b, actual char %h last %b",
                     $time, want.ch, want.last, out_mon_i.text_char, out_mon_i.last_char);
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_text.size();
  end

endmodule

// ===== verif/testbench.sv =====
// top of the testbench: clock, reset, stimulus and verdict for the decimal text converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b2da_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_cnt;
  int unsigned pending_chars;
  int unsigned items_sent = 0;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  b2da_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_chars)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t pick_word();
    word_t p10;
    word_t w;
    case ($urandom_range(0, 9))
      4: w = $urandom_range(0, 99);
      5: begin
        p10 = 1;
        repeat ($urandom_range(1, 9)) p10 = p10 * 10;
        w = p10 + $urandom_range(0, 2) - 1;
      end
      6: w = ~word_t'($urandom_range(1, 1000)) + word_t'(1);
      7: begin
        case ($urandom_range(0, 2))
          0: w = 32'h8000_0000 + $urandom_range(0, 3);
          1: w = 32'h7FFF_FFFF - $urandom_range(0, 3);
          default: w = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
      end
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(word_t w, logic act);
    in_if.valid  <= 1'b1;
    in_if.value  <= w;
    in_if.action <= act;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
  endtask

  // receiver side: random stalls, calm stretches and one long hold
  initial begin
    int unsigned r;
    int unsigned hold;
    int unsigned cyc;
    bit          long_hold_done;
    out_if.ready <= 1'b0;
    hold = 0;
    cyc = 0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && items_sent >= 120) begin
        long_hold_done = 1'b1;
        hold = 399;
        out_if.ready <= 1'b0;
      end else if (cyc % 600 < 120) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
    end
  end

  initial begin
    static word_t corner_words[20] = '{
      32'd0, 32'd0, 32'd1, 32'd9, 32'd10,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'd999_999_999, 32'd1_000_000_000, 32'hFFFF_FFF6, 32'h8000_0001,
      32'd3_999_999_999, 32'd123_456_789, 32'hAAAA_AAAA, 32'h5555_5555, 32'd100
    };
    static logic corner_acts[20] = '{
      ActUnsigned, ActSigned, ActUnsigned, ActUnsigned, ActSigned,
      ActUnsigned, ActSigned, ActSigned, ActUnsigned, ActSigned,
      ActUnsigned, ActUnsigned, ActSigned, ActSigned, ActSigned,
      ActUnsigned, ActSigned, ActUnsigned, ActSigned, ActSigned
    };
    int unsigned gap;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    in_if.action <= ActUnsigned;
    rst_n        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_words[i]) begin
      send_word(corner_words[i], corner_acts[i]);
      idle_sender(pick_gap());
    end

    for (int i = 0; i < 400; i++) begin
      if (i == 300) wait_for_drain();
      send_word(pick_word(), logic'($urandom_range(0, 1)));
      gap = (i % 100 < 20) ? 0 : pick_gap();
      idle_sender(gap);
    end

    wait_for_drain();
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && pending_chars == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== binary_to_decimal_ascii_unit.f =====
rtl/b2da_pkg.sv
rtl/b2da_if.sv
rtl/b2da_dabble.sv
rtl/binary_to_decimal_ascii_unit.sv
verif/b2da_checker.sv
verif/testbench.sv
